@@ src/mcpwm_pkg.sv @@
package mcpwm_pkg;

  localparam int CHANNELS_DEF = 8;

  // timing arithmetic
  localparam int NUM_W = 16;   // 125*255 and 64000 both fit
  localparam int DEN_W = 18;   // 1023*255 fits
  localparam logic [NUM_W-1:0] HIGH_SCALE = 16'd125;
  localparam logic [NUM_W-1:0] LOW_NUM    = 16'd64000;

  localparam logic [9:0] FREQ_RESET = 10'd100;
  localparam logic [7:0] DUTY_RESET = 8'd128;
  localparam logic [9:0] DUTY_MAX   = 10'd255;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_DUTY = 2'd1;
  localparam logic [1:0] OP_FREQ = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  channel;
    logic [9:0]  setting;
    logic [31:0] now_ms;
  } pwm_in_t;

  typedef struct packed {
    logic [7:0] levels;
    logic [7:0] toggled;
  } pwm_out_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_DUTY,
    CMD_FREQ,
    CMD_NOP
  } cmd_kind_t;

  // classified word as held in the queue
  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  channel;
    logic [9:0]  value;
    logic [31:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ src/multi_channel_soft_pwm_top.sv @@
// Multi-channel PWM generator. Words arrive on the req channel: a tick carries the
// current millisecond time, a set word changes one channel's duty word (0 is taken
// as 1, above 255 as 255) or its frequency in Hz. Every word gives exactly one
// response word with the channel levels after it and, for a tick, the channels
// that toggled. A front end classifies words into a two-word queue, so req is
// taken while the back end is still busy or a response waits on rsp. The back end
// walks the channels one at a time through a single shared 16-step divider; a
// channel held at frequency zero is passed over without a division. Only
// channels 0..7 are addressable and shown in the result; further channels run
// from their reset settings.
module multi_channel_soft_pwm_top #(
  parameter int CHANNELS = mcpwm_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  mcpwm_pkg::pwm_in_t  req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output mcpwm_pkg::pwm_out_t rsp
);
  import mcpwm_pkg::*;

  logic     q_valid;
  logic     q_ready;
  cmd_t     q_cmd;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // accept and classify
  mcpwm_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd)
  );

  // shared divider for the level times
  mcpwm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  // channel state, tick walk and response register
  mcpwm_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

`ifndef SYNTH
  // divider works in steps; a result right after a start means a lost word
  a_div_latency: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> !div_rsp.done)
    else $error("divider finished one cycle after start");

  // back end goes busy once it has taken a queued word
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |=> !q_ready)
    else $error("back end still idle after taking a word");

  // divider only finishes while a tick is being walked
  a_done_in_tick: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> !q_ready)
    else $error("divider result with back end idle");
`endif

endmodule

@@ src/mcpwm_front.sv @@
module mcpwm_front #(
  parameter int CHANNELS = mcpwm_pkg::CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  mcpwm_pkg::pwm_in_t req,
  output logic              q_valid,
  input  logic              q_ready,
  output mcpwm_pkg::cmd_t   q_cmd
);
  import mcpwm_pkg::*;

  cmd_t       qmem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  cmd_t       cls;
  logic       ch_ok;
  logic       push;
  logic       pop;

  assign ch_ok = (32'(req.channel) < CHANNELS);

  always_comb begin
    cls.channel = req.channel;
    cls.now_ms  = req.now_ms;
    cls.value   = req.setting;
    unique case (req.opcode)
      OP_TICK: cls.kind = CMD_TICK;
      OP_DUTY: begin
        cls.kind = ch_ok ? CMD_DUTY : CMD_NOP;
        // duty saturates to 1..255
        if (req.setting == 10'd0) begin
          cls.value = 10'd1;
        end else if (req.setting > DUTY_MAX) begin
          cls.value = DUTY_MAX;
        end
      end
      OP_FREQ: cls.kind = ch_ok ? CMD_FREQ : CMD_NOP;
      default: cls.kind = CMD_NOP;
    endcase
  end

  assign req_stall = (cnt == 2'd2);
  assign q_valid   = (cnt != 2'd0);
  assign q_cmd     = qmem[rp];
  assign push      = req_valid && !req_stall;
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        qmem[wp] <= cls;
        wp       <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ src/mcpwm_div.sv @@
module mcpwm_div (
  input  logic                clk,
  input  logic                rst,
  input  mcpwm_pkg::div_req_t div_req,
  output mcpwm_pkg::div_rsp_t div_rsp
);
  import mcpwm_pkg::*;

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] q;
  logic [3:0]       cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;
  logic             fits;

  // restoring division, one quotient bit a cycle
  assign trial = {rem, q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (div_req.start) begin
        rem  <= '0;
        den  <= div_req.den;
        q    <= div_req.num;
        cnt  <= 4'(NUM_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        q   <= {q[NUM_W-2:0], fits};
        cnt <= cnt - 4'd1;
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign div_rsp.done = done;
  assign div_rsp.quo  = q;

endmodule

@@ src/mcpwm_back.sv @@
module mcpwm_back #(
  parameter int CHANNELS = mcpwm_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  mcpwm_pkg::cmd_t     q_cmd,
  output mcpwm_pkg::div_req_t div_req,
  input  mcpwm_pkg::div_rsp_t div_rsp,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output mcpwm_pkg::pwm_out_t rsp
);
  import mcpwm_pkg::*;

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_WAIT,
    S_FINISH
  } state_t;

  state_t        state;
  cmd_t          cmd;
  logic [IW-1:0] idx;
  logic [7:0]    tog;

  logic [9:0]          freq    [CHANNELS];
  logic [7:0]          duty    [CHANNELS];
  logic [31:0]         last_ms [CHANNELS];
  logic [CHANNELS-1:0] level;

  logic [9:0]    cur_f;
  logic [7:0]    cur_d;
  logic [31:0]   elapsed;
  logic          reached;
  logic          last_ch;
  logic [IW-1:0] set_idx;
  logic [7:0]    lvl_map;

  assign cur_f   = freq[idx];
  assign cur_d   = duty[idx];
  assign elapsed = cmd.now_ms - last_ms[idx];
  assign reached = (elapsed >= {16'd0, div_rsp.quo});
  assign last_ch = (idx == IW'(CHANNELS - 1));
  assign set_idx = IW'(q_cmd.channel);
  assign q_ready = (state == S_IDLE);

  // high: 125*d / (32*f), low: 64000 / (f*d)
  always_comb begin
    div_req.start = (state == S_LOAD) && (cur_f != 10'd0);
    if (level[idx]) begin
      div_req.num = {8'd0, cur_d} * HIGH_SCALE;
      div_req.den = {3'd0, cur_f, 5'd0};
    end else begin
      div_req.num = LOW_NUM;
      div_req.den = DEN_W'(cur_f) * DEN_W'(cur_d);
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_map
    if (g < CHANNELS) begin : g_on
      assign lvl_map[g] = level[g];
    end else begin : g_off
      assign lvl_map[g] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      idx       <= '0;
      tog       <= '0;
      level     <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        freq[i]    <= FREQ_RESET;
        duty[i]    <= DUTY_RESET;
        last_ms[i] <= '0;
      end
    end else begin
      // S_FINISH reloads the register itself when the old word is taken
      if (rsp_valid && !rsp_stall && (state != S_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd <= q_cmd;
            idx <= '0;
            tog <= '0;
            case (q_cmd.kind)
              CMD_TICK: state <= S_LOAD;
              CMD_DUTY: begin
                duty[set_idx] <= q_cmd.value[7:0];
                state         <= S_FINISH;
              end
              CMD_FREQ: begin
                freq[set_idx] <= q_cmd.value;
                state         <= S_FINISH;
              end
              default: state <= S_FINISH;
            endcase
          end
        end
        S_LOAD: begin
          if (cur_f == 10'd0) begin
            level[idx] <= 1'b0;
            if (last_ch) begin
              state <= S_FINISH;
            end else begin
              idx <= idx + IW'(1);
            end
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            if (reached) begin
              level[idx]   <= ~level[idx];
              last_ms[idx] <= cmd.now_ms;
              tog          <= tog | (8'd1 << idx);
            end
            if (last_ch) begin
              state <= S_FINISH;
            end else begin
              idx   <= idx + IW'(1);
              state <= S_LOAD;
            end
          end
        end
        S_FINISH: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.levels  <= lvl_map;
            rsp.toggled <= tog;
            rsp_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ dv/tb_multi_channel_soft_pwm_top.sv @@
module tb_multi_channel_soft_pwm_top;
  import mcpwm_pkg::*;

  localparam int NCH = CHANNELS_DEF;

  // opcode 3 has no meaning; the block must drop it but still answer with the levels
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int DIR_N           = 25;
  localparam int RAND_WORDS      = 1500;
  localparam int PRESSURE_CYCLES = 1200;  // long enough to fill the two-word queue
  localparam int DRAIN_CYCLES    = 400;   // margin for a tick walk plus rsp stalls

  // one row of the directed table: the word, and a typed answer where it is obvious
  typedef struct packed {
    pwm_in_t  word;
    logic     typed;
    pwm_out_t want;
  } dir_row_t;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  pwm_in_t  req       = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  pwm_out_t rsp;

  // predictor copy of the per-channel state
  logic [9:0]  ch_freq  [NCH];
  logic [7:0]  ch_duty  [NCH];
  logic [31:0] ch_last  [NCH];
  logic        ch_level [NCH];

  pwm_out_t due_words [$];   // answers still owed by the block, oldest first
  int       fault_count = 0;
  int       words_out   = 0;
  bit       calm        = 1'b0;  // sender runs without gaps while set

  dir_row_t dir_rows [DIR_N];

  multi_channel_soft_pwm_top #(.CHANNELS(NCH)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Run limit, well above the slowest legal run (every word a tick, long gaps, long stalls).
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic dir_row_t mk_row(input logic [1:0] op, input logic [2:0] ch,
                                      input logic [9:0] setting, input logic [31:0] now,
                                      input logic typed, input logic [7:0] lv,
                                      input logic [7:0] tg);
    dir_row_t row;
    row.word.opcode  = op;
    row.word.channel = ch;
    row.word.setting = setting;
    row.word.now_ms  = now;
    row.typed        = typed;
    row.want.levels  = lv;
    row.want.toggled = tg;
    return row;
  endfunction

  // Applies one word to the predictor state and returns the answer it should give.
  // High time = 125*duty/(32*freq) ms, low time = 64000/(freq*duty) ms, both truncated.
  function automatic pwm_out_t advance_channels(input pwm_in_t w);
    pwm_out_t    r;
    logic [31:0] span;
    logic [31:0] dwell;
    logic [9:0]  d;
    r = '0;
    case (w.opcode)
      OP_TICK: begin
        for (int i = 0; i < NCH; i++) begin
          if (ch_freq[i] == '0) begin
            ch_level[i] = 1'b0;   // forced low, not counted as a toggle
          end else begin
            span = w.now_ms - ch_last[i];   // wraps modulo 2^32
            if (ch_level[i]) dwell = (32'd125 * ch_duty[i]) / (32'd32 * ch_freq[i]);
            else dwell = 32'd64000 / (32'(ch_freq[i]) * ch_duty[i]);
            if (span >= dwell) begin
              ch_last[i]  = w.now_ms;
              ch_level[i] = ~ch_level[i];
              if (i < 8) r.toggled[i] = 1'b1;
            end
          end
        end
      end
      OP_DUTY: begin
        d = w.setting;
        if (d == '0) begin
          d = 10'd1;
        end else if (d > DUTY_MAX) begin
          d = DUTY_MAX;
        end
        if (w.channel < NCH) ch_duty[w.channel] = d[7:0];
      end
      OP_FREQ: begin
        if (w.channel < NCH) ch_freq[w.channel] = w.setting;
      end
      default: ;   // unused opcode: nothing changes
    endcase
    for (int i = 0; i < NCH && i < 8; i++) r.levels[i] = ch_level[i];
    return r;
  endfunction

  // Offers one word after a random gap, holds it until taken, then books its answer.
  // Entered and left just after a falling edge.
  task automatic send_word(input pwm_in_t w, input logic typed, input pwm_out_t want);
    int          gap;
    int          r;
    logic [63:0] idle_noise;
    pwm_out_t    model_out;
    r = $urandom_range(0, 99);
    if (calm || r < 50) begin
      gap = 0;
    end else if (r < 88) begin
      gap = $urandom_range(1, 3);
    end else if (r < 97) begin
      gap = $urandom_range(4, 12);
    end else begin
      gap = $urandom_range(25, 60);
    end
    if (gap > 0) begin
      idle_noise = {$urandom, $urandom};
      req_valid  = 1'b0;
      req        = idle_noise[$bits(pwm_in_t)-1:0];   // junk while idle must be ignored
      repeat (gap) @(negedge clk);
    end
    req_valid = 1'b1;
    req       = w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    model_out = advance_channels(w);
    due_words.push_back(typed ? want : model_out);
    @(negedge clk);
  endtask

  // Response checker: every taken answer against the oldest one owed.
  always @(posedge clk) begin : rsp_check
    pwm_out_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      words_out++;
      if (due_words.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected answer levels %02h toggled %02h",
                 $time, rsp.levels, rsp.toggled);
      end else begin
        want = due_words.pop_front();
        if (rsp.levels !== want.levels) begin
          fault_count++;
          $display("%0t: levels expected %02h, got %02h", $time, want.levels, rsp.levels);
        end
        if (rsp.toggled !== want.toggled) begin
          fault_count++;
          $display("%0t: toggled expected %02h, got %02h",
                   $time, want.toggled, rsp.toggled);
        end
      end
    end
  end

  // Receiver: short random stalls, some long ones, quiet stretches, and a few long
  // hold-offs while the sender keeps going so that req_stall has to rise.
  initial begin : rsp_side
    int hold;
    int cyc;
    int next_holdoff;
    int r;
    hold         = 0;
    cyc          = 0;
    next_holdoff = 60;
    wait (!rst);
    forever begin
      @(negedge clk);
      cyc++;
      if (words_out >= next_holdoff) begin
        rsp_stall    = 1'b1;
        next_holdoff = next_holdoff + 700;
        repeat (PRESSURE_CYCLES) @(negedge clk);
      end else if (hold > 0) begin
        rsp_stall = 1'b1;
        hold--;
      end else if ((cyc % 4000) < 800) begin
        rsp_stall = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          rsp_stall = 1'b0;
        end else begin
          rsp_stall = 1'b1;
          if (r < 85) begin
            hold = $urandom_range(0, 2);
          end else if (r < 97) begin
            hold = $urandom_range(3, 9);
          end else begin
            hold = $urandom_range(20, 40);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int          n;
    int          meaningful;
    int          pick;
    int          sub;
    logic [31:0] now_cursor;
    logic [63:0] noise;
    pwm_in_t     w;

    for (int i = 0; i < NCH; i++) begin
      ch_freq[i]  = FREQ_RESET;
      ch_duty[i]  = DUTY_RESET;
      ch_last[i]  = '0;
      ch_level[i] = 1'b0;
    end

    // Directed table. Typed answers only where they follow at once from the reset
    // settings (100 Hz, duty word 128: 5 ms low, 5 ms high); the rest go to the predictor.
    dir_rows = '{
      // just out of reset: nothing has run its low time yet
      mk_row(OP_TICK,   3'd0, 10'd0,    32'd0,         1'b1, 8'h00, 8'h00),
      mk_row(OP_TICK,   3'd7, 10'd1023, 32'd4,         1'b1, 8'h00, 8'h00),
      // low time reached on every channel at once
      mk_row(OP_TICK,   3'd0, 10'd0,    32'd5,         1'b1, 8'hFF, 8'hFF),
      mk_row(OP_TICK,   3'd0, 10'd0,    32'd9,         1'b1, 8'hFF, 8'h00),
      // unused opcode with every field at its top
      mk_row(OP_UNUSED, 3'd7, 10'd1023, 32'hFFFF_FFFF, 1'b1, 8'hFF, 8'h00),
      // duty zero taken as 1, above 255 saturates
      mk_row(OP_DUTY,   3'd0, 10'd0,    32'd0,         1'b1, 8'hFF, 8'h00),
      mk_row(OP_DUTY,   3'd1, 10'd1023, 32'hFFFF_FFFF, 1'b1, 8'hFF, 8'h00),
      mk_row(OP_DUTY,   3'd5, 10'd256,  32'd0,         1'b1, 8'hFF, 8'h00),
      // frequency zero (held low), above 1000, and the slowest
      mk_row(OP_FREQ,   3'd2, 10'd0,    32'd0,         1'b1, 8'hFF, 8'h00),
      mk_row(OP_FREQ,   3'd3, 10'd1023, 32'd0,         1'b1, 8'hFF, 8'h00),
      mk_row(OP_FREQ,   3'd4, 10'd1,    32'd0,         1'b1, 8'hFF, 8'h00),
      mk_row(OP_DUTY,   3'd4, 10'd255,  32'd0,         1'b1, 8'hFF, 8'h00),
      // from here on the predictor decides
      mk_row(OP_TICK,   3'd0, 10'd0,    32'd10,        1'b0, 8'h00, 8'h00),
      mk_row(OP_TICK,   3'd0, 10'd0,    32'd11,        1'b0, 8'h00, 8'h00),
      // time jumps backwards to just before the wrap, then wraps past zero
      mk_row(OP_TICK,   3'd0, 10'd0,    32'hFFFF_FFF0, 1'b0, 8'h00, 8'h00),
      mk_row(OP_TICK,   3'd0, 10'd0,    32'd3,         1'b0, 8'h00, 8'h00),
      mk_row(OP_FREQ,   3'd2, 10'h2AA,  32'd0,         1'b0, 8'h00, 8'h00),
      mk_row(OP_FREQ,   3'd5, 10'h155,  32'd0,         1'b0, 8'h00, 8'h00),
      mk_row(OP_FREQ,   3'd6, 10'd1000, 32'd0,         1'b0, 8'h00, 8'h00),
      mk_row(OP_DUTY,   3'd7, 10'd1,    32'd0,         1'b0, 8'h00, 8'h00),
      mk_row(OP_TICK,   3'd0, 10'd0,    32'hAAAA_AAAA, 1'b0, 8'h00, 8'h00),
      mk_row(OP_TICK,   3'd0, 10'd0,    32'h5555_5555, 1'b0, 8'h00, 8'h00),
      mk_row(OP_TICK,   3'd0, 10'd0,    32'h5555_5556, 1'b0, 8'h00, 8'h00),
      // a running channel stopped by frequency zero drops low on the next tick
      mk_row(OP_FREQ,   3'd0, 10'd0,    32'd0,         1'b0, 8'h00, 8'h00),
      mk_row(OP_TICK,   3'd0, 10'd0,    32'h5555_5600, 1'b0, 8'h00, 8'h00)
    };

    repeat (5) @(negedge clk);
    rst = 1'b0;

    for (int k = 0; k < DIR_N; k++) begin
      send_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].want);
    end

    // Random part: mostly ticks on a clock that creeps forward a few ms at a time,
    // so channels really cycle; now and then a big step, a jump anywhere (backwards
    // too) or a run up to the 32-bit wrap. Set words use random channels and values,
    // with zero and over-range values mixed in. Ignored bits are random throughout.
    now_cursor = $urandom_range(0, 1000);
    meaningful = 0;
    n          = 0;
    while (meaningful < RAND_WORDS) begin
      calm  = (n % 250) < 40;
      pick  = $urandom_range(0, 99);
      sub   = $urandom_range(0, 99);
      noise = {$urandom, $urandom};
      w     = noise[$bits(pwm_in_t)-1:0];
      if (pick < 70) begin
        w.opcode = OP_TICK;
        if (sub < 85) begin
          now_cursor = now_cursor + $urandom_range(0, 9);
        end else if (sub < 93) begin
          now_cursor = now_cursor + $urandom_range(10, 400);
        end else if (sub < 97) begin
          now_cursor = $urandom;
        end else begin
          now_cursor = 32'hFFFF_FFFF - $urandom_range(0, 30);
        end
        w.now_ms = now_cursor;
      end else if (pick < 84) begin
        w.opcode = OP_DUTY;
        if (sub < 80) begin
          w.setting = 10'($urandom_range(1, 255));
        end else if (sub < 88) begin
          w.setting = '0;
        end else begin
          w.setting = 10'($urandom_range(256, 1023));
        end
      end else if (pick < 98) begin
        w.opcode = OP_FREQ;
        if (sub < 50) begin
          w.setting = 10'($urandom_range(20, 300));
        end else if (sub < 70) begin
          w.setting = 10'($urandom_range(301, 1023));
        end else if (sub < 82) begin
          w.setting = '0;
        end else begin
          w.setting = 10'($urandom_range(1, 19));
        end
      end else begin
        w.opcode = OP_UNUSED;
      end
      send_word(w, 1'b0, '0);
      if (w.opcode != OP_UNUSED) meaningful++;
      n++;
    end
    req_valid = 1'b0;

    // all words in; wait for the owed answers, then watch a while for strays
    while (due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
